// ===== design/integer_matrix_multiply_defines.svh =====
// Assertion macros shared by the integer matrix multiplier modules
// Expects a clock named clk and an active-low reset named rst_n in the using module

`ifndef INTEGER_MATRIX_MULTIPLY_DEFINES_SVH
`define INTEGER_MATRIX_MULTIPLY_DEFINES_SVH

// same-cycle implication, checked out of reset
`define IMM_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define IMM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/imm_pkg.sv =====
// Package for the integer matrix multiplier: field widths, codes and request types
// No dependencies; used by every module of the block but imm_store

package imm_pkg;

    // parameter defaults
    localparam int MAX_DIM_DEFAULT    = 8;
    localparam int DATA_WIDTH_DEFAULT = 32;

    // fixed field widths
    localparam int DIM_W     = 4;
    localparam int REG_IDX_W = 2;
    localparam int MODE_W    = 2;
    localparam int POS_W     = 3;
    localparam int VALUE_W   = 32;
    localparam int MULT_W_MAX = 32;

    // configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_COLS_B    = 2'd2;

    // command modes
    localparam logic [MODE_W-1:0] MODE_LOAD_A  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_B  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;

    // command request
    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic [POS_W-1:0]          elem_row;
        logic [POS_W-1:0]          elem_col;
        logic signed [VALUE_W-1:0] elem_value;
    } cmd_t;

    // result request
    typedef struct packed {
        logic [POS_W-1:0]          out_row;
        logic [POS_W-1:0]          out_col;
        logic signed [VALUE_W-1:0] out_value;
        logic                      last;
    } res_t;

    // one multiply-accumulate operation travelling down the datapath
    typedef struct packed {
        logic             valid;
        logic             first_op;
        logic             end_op;
        logic             last_elem;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             piece_a;
        logic             piece_b;
    } mac_tok_t;

endpackage

// ===== design/imm_store.sv =====
// Matrix element store: one write port, one registered read port
// Per-entry fill bits make unwritten entries read as zero; uses no package items

module imm_store #(
    parameter int DEPTH      = 64,
    parameter int ADDR_W     = 6,
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  logic [DATA_WIDTH-1:0] wr_data,
    input  logic                  rd_en,
    input  logic [ADDR_W-1:0]     rd_addr,
    output logic [DATA_WIDTH-1:0] rd_data
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0]      filled_reg;
    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic                  rd_filled_reg;

    // storage array
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // fill bits, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg    <= '0;
            rd_filled_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                filled_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_filled_reg <= filled_reg[rd_addr];
            end
        end
    end

    // never-written entries read as zero
    assign rd_data = rd_filled_reg ? rd_data_reg : '0;

endmodule

// ===== design/imm_seq.sv =====
// Sequencer of the matrix multiplier: dimension registers and row/column/inner loops
// Depends on imm_pkg and the assertion macros in integer_matrix_multiply_defines.svh

`include "integer_matrix_multiply_defines.svh"

module imm_seq #(
    parameter int MAX_DIM    = imm_pkg::MAX_DIM_DEFAULT,
    parameter int DATA_WIDTH = imm_pkg::DATA_WIDTH_DEFAULT,
    parameter int ADDR_W     = (MAX_DIM * MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [imm_pkg::REG_IDX_W-1:0]  cfg_index,
    input  logic [imm_pkg::DIM_W-1:0]      cfg_data,
    input  logic                           cmd_go,
    input  logic                           advance,
    input  logic                           mac_busy,
    output logic                           idle,
    output imm_pkg::mac_tok_t              tok,
    output logic [ADDR_W-1:0]              rd_addr_a,
    output logic [ADDR_W-1:0]              rd_addr_b
);

    localparam int IDX_W      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int MULT_W     = (DATA_WIDTH > imm_pkg::MULT_W_MAX) ?
                                imm_pkg::MULT_W_MAX : DATA_WIDTH;
    localparam int NUM_PIECES = (DATA_WIDTH + MULT_W - 1) / MULT_W;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ISSUE = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [imm_pkg::DIM_W-1:0] rows_a_reg, inner_dim_reg, cols_b_reg;
    logic [IDX_W-1:0]          i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic                      pa_reg, pa_next, pb_reg, pb_next;

    logic [IDX_W-1:0] lim_i, lim_j, lim_k;
    logic [1:0]       piece_sum;
    logic [1:0]       np_m1;
    logic             pieces_done;
    logic             i_done, j_done, k_done;

    // clamp a dimension to 1..MAX_DIM and give its last index
    function automatic logic [IDX_W-1:0] last_index(input logic [imm_pkg::DIM_W-1:0] v);
        logic [imm_pkg::DIM_W-1:0] c;
        c = v;
        if (v == '0)
        begin
            c = imm_pkg::DIM_W'(1);
        end
        else if (v > imm_pkg::DIM_W'(MAX_DIM))
        begin
            c = imm_pkg::DIM_W'(MAX_DIM);
        end
        return IDX_W'(c - imm_pkg::DIM_W'(1));
    endfunction

    // dimension registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg    <= imm_pkg::DIM_W'(8);
            inner_dim_reg <= imm_pkg::DIM_W'(8);
            cols_b_reg    <= imm_pkg::DIM_W'(8);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                imm_pkg::REG_ROWS_A:    rows_a_reg    <= cfg_data;
                imm_pkg::REG_INNER_DIM: inner_dim_reg <= cfg_data;
                imm_pkg::REG_COLS_B:    cols_b_reg    <= cfg_data;
                default:                ;
            endcase
        end
    end

    // loop limits and end conditions
    always_comb
    begin
        lim_i       = last_index(rows_a_reg);
        lim_k       = last_index(inner_dim_reg);
        lim_j       = last_index(cols_b_reg);
        piece_sum   = {1'b0, pa_reg} + {1'b0, pb_reg};
        np_m1       = 2'(NUM_PIECES - 1);
        pieces_done = !(piece_sum < np_m1) && !({1'b0, pa_reg} < np_m1);
        i_done      = (i_reg == lim_i);
        j_done      = (j_reg == lim_j);
        k_done      = (k_reg == lim_k);
    end

    // operation issued this cycle
    always_comb
    begin
        tok.valid     = (state_reg == ST_ISSUE);
        tok.first_op  = (k_reg == '0) && !pa_reg && !pb_reg;
        tok.end_op    = k_done && pieces_done;
        tok.last_elem = k_done && pieces_done && i_done && j_done;
        tok.row       = imm_pkg::POS_W'(i_reg);
        tok.col       = imm_pkg::POS_W'(j_reg);
        tok.piece_a   = pa_reg;
        tok.piece_b   = pb_reg;
        rd_addr_a     = ADDR_W'(i_reg) * ADDR_W'(MAX_DIM) + ADDR_W'(k_reg);
        rd_addr_b     = ADDR_W'(k_reg) * ADDR_W'(MAX_DIM) + ADDR_W'(j_reg);
    end

    // loop stepping: pieces, then inner, then column, then row
    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        pa_next    = pa_reg;
        pb_next    = pb_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_go)
                begin
                    state_next = ST_ISSUE;
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                    pa_next    = 1'b0;
                    pb_next    = 1'b0;
                end
            end
            ST_ISSUE:
            begin
                if (advance)
                begin
                    if (piece_sum < np_m1)
                    begin
                        pb_next = 1'b1;
                    end
                    else if ({1'b0, pa_reg} < np_m1)
                    begin
                        pa_next = 1'b1;
                        pb_next = 1'b0;
                    end
                    else
                    begin
                        pa_next = 1'b0;
                        pb_next = 1'b0;
                        if (!k_done)
                        begin
                            k_next = k_reg + 1'b1;
                        end
                        else
                        begin
                            k_next = '0;
                            if (!j_done)
                            begin
                                j_next = j_reg + 1'b1;
                            end
                            else
                            begin
                                j_next = '0;
                                if (!i_done)
                                begin
                                    i_next = i_reg + 1'b1;
                                end
                                else
                                begin
                                    state_next = ST_DRAIN;
                                end
                            end
                        end
                    end
                end
            end
            ST_DRAIN:
            begin
                if (!mac_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            pa_reg    <= 1'b0;
            pb_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            pa_reg    <= pa_next;
            pb_reg    <= pb_next;
        end
    end

    assign idle = (state_reg == ST_IDLE);

    // checks
    `IMM_ASSERT_IMPL(a_idle_pipe_empty, state_reg == ST_IDLE, !mac_busy,
                     "datapath busy while idle")
    `IMM_ASSERT_NEXT(a_last_to_drain, tok.valid && advance && tok.last_elem,
                     state_reg == ST_DRAIN, "no drain after last operation")
    `IMM_ASSERT_NEXT(a_go_to_issue, (state_reg == ST_IDLE) && cmd_go,
                     (state_reg == ST_ISSUE) && (i_reg == '0) && (k_reg == '0),
                     "compute did not start at origin")

endmodule

// ===== design/imm_mac.sv =====
// Shared multiply-accumulate datapath and result output register
// Depends on imm_pkg and the assertion macros in integer_matrix_multiply_defines.svh

`include "integer_matrix_multiply_defines.svh"

module imm_mac #(
    parameter int DATA_WIDTH = imm_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  imm_pkg::mac_tok_t     tok,
    input  logic [DATA_WIDTH-1:0] rd_a,
    input  logic [DATA_WIDTH-1:0] rd_b,
    output logic                  advance,
    output logic                  busy,
    output logic                  res_valid,
    input  logic                  res_stall,
    output imm_pkg::res_t         res
);

    localparam int MULT_W  = (DATA_WIDTH > imm_pkg::MULT_W_MAX) ?
                             imm_pkg::MULT_W_MAX : DATA_WIDTH;
    localparam int PROD_W  = 2 * MULT_W;
    localparam int SHIFT_W = 7;

    imm_pkg::mac_tok_t s1_tok_reg, s2_tok_reg;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic [MULT_W-1:0]     a_pc, b_pc;
    logic [DATA_WIDTH-1:0] acc_reg, acc_next;
    logic [DATA_WIDTH-1:0] term, sum;
    logic [1:0]            s2_sum;
    logic                  res_valid_reg, res_valid_next;
    imm_pkg::res_t         res_reg, res_next;

    // the whole datapath moves unless a finished result is held back
    assign advance = !res_valid_reg || !res_stall;
    assign busy    = s1_tok_reg.valid || s2_tok_reg.valid;

    // operand piece select and multiply
    always_comb
    begin
        a_pc      = s1_tok_reg.piece_a ? MULT_W'(rd_a >> MULT_W) : MULT_W'(rd_a);
        b_pc      = s1_tok_reg.piece_b ? MULT_W'(rd_b >> MULT_W) : MULT_W'(rd_b);
        prod_next = PROD_W'(a_pc) * PROD_W'(b_pc);
    end

    // align partial product and accumulate
    always_comb
    begin
        s2_sum = {1'b0, s2_tok_reg.piece_a} + {1'b0, s2_tok_reg.piece_b};
        term   = DATA_WIDTH'(prod_reg) << (SHIFT_W'(s2_sum) * SHIFT_W'(MULT_W));
        sum    = (s2_tok_reg.first_op ? '0 : acc_reg) + term;
    end

    // accumulator and result register next values
    always_comb
    begin
        acc_next       = acc_reg;
        res_valid_next = res_valid_reg && res_stall;
        res_next       = res_reg;
        if (advance && s2_tok_reg.valid)
        begin
            acc_next = sum;
            if (s2_tok_reg.end_op)
            begin
                res_valid_next     = 1'b1;
                res_next.out_row   = s2_tok_reg.row;
                res_next.out_col   = s2_tok_reg.col;
                res_next.out_value = imm_pkg::VALUE_W'(signed'(sum));
                res_next.last      = s2_tok_reg.last_elem;
            end
        end
    end

    // pipeline control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tok_reg    <= '0;
            s2_tok_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                s1_tok_reg <= tok;
                s2_tok_reg <= s1_tok_reg;
            end
            res_valid_reg <= res_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_reg <= prod_next;
        end
        acc_reg <= acc_next;
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // checks
    `IMM_ASSERT_IMPL(a_res_from_end_op, $rose(res_valid_reg), $past(s2_tok_reg.valid && s2_tok_reg.end_op), "result without a finished dot product")
    `IMM_ASSERT_NEXT(a_hold_on_stall, res_valid_reg && res_stall, $stable(acc_reg) && $stable(s2_tok_reg), "datapath moved while result held")

endmodule

// ===== design/integer_matrix_multiply.sv =====
// Top level of the integer matrix multiplier: load decode, element stores, sequencer, datapath
// Depends on imm_pkg, imm_store, imm_seq and imm_mac

// Loads of A and B elements (modes 0 and 1) are taken one per cycle while idle; loads with
// a row or column of MAX_DIM or more, and mode 3, are taken and do nothing. A compute command
// holds cmd_stall high until the product is done: it runs rows_a * cols_b * inner_dim * P
// operations through the one shared multiplier, one per cycle while no finished result waits
// on res_stall, where P is 1 for DATA_WIDTH up to 32 and 3 above (32-bit partial products),
// then drains the pipeline. Results leave in row-major order with last set on the final one.
// Both stores read as zero after reset through per-entry fill bits, so no clearing pass is
// needed. The user must write dimensions only while the block is idle; the block does not
// enforce this. 0 acts as 1 and values above MAX_DIM act as MAX_DIM.

module integer_matrix_multiply #(
    parameter int MAX_DIM    = imm_pkg::MAX_DIM_DEFAULT,
    parameter int DATA_WIDTH = imm_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_stall,
    input  imm_pkg::cmd_t                 cmd,
    output logic                          res_valid,
    input  logic                          res_stall,
    output imm_pkg::res_t                 res,
    input  logic                          cfg_we,
    input  logic [imm_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [imm_pkg::DIM_W-1:0]     cfg_data
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                  idle;
    logic                  cmd_accept;
    logic                  cmd_go;
    logic                  in_range;
    logic                  we_a, we_b;
    logic [ADDR_W-1:0]     wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic                  advance;
    logic                  mac_busy;
    imm_pkg::mac_tok_t     tok;
    logic [ADDR_W-1:0]     rd_addr_a, rd_addr_b;
    logic [DATA_WIDTH-1:0] rd_a, rd_b;

    // request decode
    always_comb
    begin
        cmd_stall  = !idle;
        cmd_accept = cmd_valid && idle;
        cmd_go     = cmd_accept && (cmd.mode == imm_pkg::MODE_COMPUTE);
        in_range   = ({1'b0, cmd.elem_row} < (imm_pkg::POS_W + 1)'(MAX_DIM)) &&
                     ({1'b0, cmd.elem_col} < (imm_pkg::POS_W + 1)'(MAX_DIM));
        we_a       = cmd_accept && in_range && (cmd.mode == imm_pkg::MODE_LOAD_A);
        we_b       = cmd_accept && in_range && (cmd.mode == imm_pkg::MODE_LOAD_B);
        wr_addr    = ADDR_W'(cmd.elem_row) * ADDR_W'(MAX_DIM) + ADDR_W'(cmd.elem_col);
        wr_data    = DATA_WIDTH'(cmd.elem_value);
    end

    // element store for A
    imm_store #(
        .DEPTH      (DEPTH),
        .ADDR_W     (ADDR_W),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_store_a (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (we_a),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (advance),
        .rd_addr (rd_addr_a),
        .rd_data (rd_a)
    );

    // element store for B
    imm_store #(
        .DEPTH      (DEPTH),
        .ADDR_W     (ADDR_W),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_store_b (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (we_b),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (advance),
        .rd_addr (rd_addr_b),
        .rd_data (rd_b)
    );

    // loop sequencer and dimension registers
    imm_seq #(
        .MAX_DIM    (MAX_DIM),
        .DATA_WIDTH (DATA_WIDTH),
        .ADDR_W     (ADDR_W)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_go    (cmd_go),
        .advance   (advance),
        .mac_busy  (mac_busy),
        .idle      (idle),
        .tok       (tok),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b)
    );

    // shared multiply-accumulate and result register
    imm_mac #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok       (tok),
        .rd_a      (rd_a),
        .rd_b      (rd_b),
        .advance   (advance),
        .busy      (mac_busy),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule

// ===== bench/tb_integer_matrix_multiply.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the integer matrix multiplier: loads, products, dimension registers
// Depends on imm_pkg and integer_matrix_multiply; its own model predicts every product element

module tb_integer_matrix_multiply;

    localparam int DIM      = imm_pkg::MAX_DIM_DEFAULT;
    localparam int SETTLE   = 16;
    localparam int ITEMS    = 350;
    localparam int SHOW_MAX = 40;

    // codes the package leaves unnamed: the spare mode and the spare register slot
    localparam logic [imm_pkg::MODE_W-1:0]    MODE_UNUSED = 2'd3;
    localparam logic [imm_pkg::REG_IDX_W-1:0] REG_UNUSED  = 2'd3;

    // one row of the directed plan: a register write or a request
    typedef struct {
        bit                            is_reg;
        logic [imm_pkg::REG_IDX_W-1:0] reg_idx;
        logic [imm_pkg::DIM_W-1:0]     reg_val;
        imm_pkg::cmd_t                 req;
        bit                            typed;
        logic [imm_pkg::VALUE_W-1:0]   typed_value;
    } plan_row_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cmd_valid;
    logic                          cmd_stall;
    imm_pkg::cmd_t                 cmd;
    logic                          res_valid;
    logic                          res_stall;
    imm_pkg::res_t                 res;
    logic                          cfg_we;
    logic [imm_pkg::REG_IDX_W-1:0] cfg_index;
    logic [imm_pkg::DIM_W-1:0]     cfg_data;

    // model state: both stores and the raw register values
    logic [imm_pkg::VALUE_W-1:0] a_words [DIM*DIM];
    logic [imm_pkg::VALUE_W-1:0] b_words [DIM*DIM];
    logic [imm_pkg::DIM_W-1:0]   dim_rows;
    logic [imm_pkg::DIM_W-1:0]   dim_inner;
    logic [imm_pkg::DIM_W-1:0]   dim_cols;

    imm_pkg::res_t pending_elems [$];
    plan_row_t     plan [$];
    bit            calm;

    int mismatch_count;
    int request_count;
    int random_items;
    int product_count;
    int element_count;
    int reg_write_count;

    integer_matrix_multiply uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // hard limit on run length
    initial
    begin : watchdog
        #100_000_000;
        $display("tb_integer_matrix_multiply: FAIL");
        $finish;
    end

    task automatic report_mismatch(string msg);
        if (mismatch_count < SHOW_MAX)
            $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // gap lengths: mostly none, some short, a few long
    function automatic int idle_len();
        int p;
        if (calm)
            return 0;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 85)
            return $urandom_range(1, 3);
        if (p < 97)
            return $urandom_range(4, 10);
        return $urandom_range(15, 30);
    endfunction

    function automatic int eff_dim(logic [imm_pkg::DIM_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > DIM)
            return DIM;
        return int'(v);
    endfunction

    function automatic logic [imm_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
            3: return $urandom_range(0, 15) - 8;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [imm_pkg::DIM_W-1:0] pick_dim();
        case ($urandom_range(0, 11))
            0: return 4'd0;
            1: return 4'd15;
            2: return 4'd8;
            3: return 4'd9;
            default: return 4'($urandom_range(1, 4));
        endcase
    endfunction

    function automatic imm_pkg::cmd_t make_req(logic [imm_pkg::MODE_W-1:0] m, int r, int c,
                                               logic [imm_pkg::VALUE_W-1:0] v);
        imm_pkg::cmd_t q;
        q.mode       = m;
        q.elem_row   = r[imm_pkg::POS_W-1:0];
        q.elem_col   = c[imm_pkg::POS_W-1:0];
        q.elem_value = v;
        return q;
    endfunction

    function automatic plan_row_t reg_row(logic [imm_pkg::REG_IDX_W-1:0] idx,
                                          logic [imm_pkg::DIM_W-1:0] val);
        plan_row_t p;
        p.is_reg      = 1'b1;
        p.reg_idx     = idx;
        p.reg_val     = val;
        p.req         = '0;
        p.typed       = 1'b0;
        p.typed_value = '0;
        return p;
    endfunction

    function automatic plan_row_t load_row(logic [imm_pkg::MODE_W-1:0] m, int r, int c,
                                           logic [imm_pkg::VALUE_W-1:0] v);
        plan_row_t p;
        p             = reg_row(imm_pkg::REG_ROWS_A, '0);
        p.is_reg      = 1'b0;
        p.req         = make_req(m, r, c, v);
        return p;
    endfunction

    function automatic plan_row_t product_row(bit typed, logic [imm_pkg::VALUE_W-1:0] tv);
        plan_row_t p;
        p             = load_row(imm_pkg::MODE_COMPUTE, 0, 0, 32'd0);
        p.typed       = typed;
        p.typed_value = tv;
        return p;
    endfunction

    // predicted product, row-major; a typed value overrides every element's value
    function automatic void queue_product(bit typed, logic [imm_pkg::VALUE_W-1:0] tv);
        int nr, nk, nc, i, j, k;
        logic [imm_pkg::VALUE_W-1:0] acc;
        imm_pkg::res_t e;
        nr = eff_dim(dim_rows);
        nk = eff_dim(dim_inner);
        nc = eff_dim(dim_cols);
        for (i = 0; i < nr; i++)
        begin
            for (j = 0; j < nc; j++)
            begin
                acc = '0;
                for (k = 0; k < nk; k++)
                    acc += a_words[i*DIM + k] * b_words[k*DIM + j];
                e.out_row   = i[imm_pkg::POS_W-1:0];
                e.out_col   = j[imm_pkg::POS_W-1:0];
                e.out_value = typed ? tv : acc;
                e.last      = (i == nr - 1) && (j == nc - 1);
                pending_elems.push_back(e);
            end
        end
        product_count++;
    endfunction

    function automatic void apply_request(imm_pkg::cmd_t c, bit typed,
                                          logic [imm_pkg::VALUE_W-1:0] tv);
        case (c.mode)
            imm_pkg::MODE_LOAD_A:  a_words[{c.elem_row, c.elem_col}] = c.elem_value;
            imm_pkg::MODE_LOAD_B:  b_words[{c.elem_row, c.elem_col}] = c.elem_value;
            imm_pkg::MODE_COMPUTE: queue_product(typed, tv);
            default: ;
        endcase
    endfunction

    // present one request and hold it until taken
    task automatic send_request(imm_pkg::cmd_t c, bit typed, logic [imm_pkg::VALUE_W-1:0] tv);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        apply_request(c, typed, tv);
        do
            @(posedge clk);
        while (cmd_stall !== 1'b0);
        request_count++;
    endtask

    // hold off until every element has arrived and the datapath has drained
    task automatic wait_idle();
        cmd_valid <= 1'b0;
        while (pending_elems.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [imm_pkg::REG_IDX_W-1:0] idx,
                             logic [imm_pkg::DIM_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            imm_pkg::REG_ROWS_A:    dim_rows  = val;
            imm_pkg::REG_INNER_DIM: dim_inner = val;
            imm_pkg::REG_COLS_B:    dim_cols  = val;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        reg_write_count++;
    endtask

    // one random job: maybe new dimensions, operand loads with noise, then the product, now and then twice
    task automatic run_job();
        imm_pkg::cmd_t batch [$];
        imm_pkg::cmd_t t;
        int nr, nk, nc, i, j, s;
        calm = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 9) < 6)
        begin
            wait_idle();
            if ($urandom_range(0, 3) != 0)
                write_reg(imm_pkg::REG_ROWS_A, pick_dim());
            if ($urandom_range(0, 3) != 0)
                write_reg(imm_pkg::REG_INNER_DIM, pick_dim());
            if ($urandom_range(0, 3) != 0)
                write_reg(imm_pkg::REG_COLS_B, pick_dim());
        end
        nr = eff_dim(dim_rows);
        nk = eff_dim(dim_inner);
        nc = eff_dim(dim_cols);

        // operands, now and then leaving an entry at its old value
        for (i = 0; i < nr; i++)
            for (j = 0; j < nk; j++)
                if ($urandom_range(0, 9) != 0)
                    batch.push_back(make_req(imm_pkg::MODE_LOAD_A, i, j, pick_value()));
        for (i = 0; i < nk; i++)
            for (j = 0; j < nc; j++)
                if ($urandom_range(0, 9) != 0)
                    batch.push_back(make_req(imm_pkg::MODE_LOAD_B, i, j, pick_value()));

        // noise: spare mode and loads anywhere in the stores
        repeat ($urandom_range(0, 2))
        begin
            if ($urandom_range(0, 1))
                batch.push_back(make_req(MODE_UNUSED, $urandom_range(0, 7),
                                         $urandom_range(0, 7), pick_value()));
            else
                batch.push_back(make_req($urandom_range(0, 1) ? imm_pkg::MODE_LOAD_B :
                                                                imm_pkg::MODE_LOAD_A,
                                         $urandom_range(0, 7), $urandom_range(0, 7),
                                         pick_value()));
        end

        for (i = batch.size() - 1; i > 0; i--)
        begin
            s        = $urandom_range(0, i);
            t        = batch[i];
            batch[i] = batch[s];
            batch[s] = t;
        end

        batch.push_back(make_req(imm_pkg::MODE_COMPUTE, $urandom_range(0, 7),
                                 $urandom_range(0, 7), $urandom()));
        if ($urandom_range(0, 9) == 0)
            batch.push_back(make_req(imm_pkg::MODE_COMPUTE, $urandom_range(0, 7),
                                     $urandom_range(0, 7), $urandom()));

        foreach (batch[n])
        begin
            send_request(batch[n], 1'b0, '0);
            if (batch[n].mode != MODE_UNUSED)
                random_items++;
        end
    endtask

    // result side: random stalls, with calm stretches
    initial
    begin : res_side
        int hold;
        hold = 0;
        res_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
                hold--;
            else if (calm)
                res_stall <= 1'b0;
            else if ($urandom_range(0, 2) == 0)
            begin
                res_stall <= 1'b1;
                hold = idle_len();
            end
            else
            begin
                res_stall <= 1'b0;
                hold = $urandom_range(0, 6);
            end
        end
    end

    // compare each accepted element with the oldest prediction
    always @(posedge clk)
    begin : res_check
        imm_pkg::res_t e;
        if (rst_n === 1'b1 && res_valid === 1'b1 && res_stall === 1'b0)
        begin
            element_count++;
            if (pending_elems.size() == 0)
                report_mismatch($sformatf("element (%0d,%0d) = %0d with none pending",
                                          res.out_row, res.out_col, res.out_value));
            else
            begin
                e = pending_elems.pop_front();
                if (res.out_row !== e.out_row)
                    report_mismatch($sformatf("out_row %0d, wanted %0d",
                                              res.out_row, e.out_row));
                if (res.out_col !== e.out_col)
                    report_mismatch($sformatf("out_col %0d, wanted %0d",
                                              res.out_col, e.out_col));
                if (res.out_value !== e.out_value)
                    report_mismatch($sformatf("(%0d,%0d) out_value %0d, wanted %0d",
                                              e.out_row, e.out_col, res.out_value,
                                              e.out_value));
                if (res.last !== e.last)
                    report_mismatch($sformatf("(%0d,%0d) last %b, wanted %b",
                                              e.out_row, e.out_col, res.last, e.last));
            end
        end
    end

    // main sequence
    initial
    begin : stimulus
        rst_n     <= 1'b0;
        cmd_valid <= 1'b0;
        cmd       <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        calm      = 1'b0;
        foreach (a_words[n])
        begin
            a_words[n] = '0;
            b_words[n] = '0;
        end
        dim_rows  = 4'd8;
        dim_inner = 4'd8;
        dim_cols  = 4'd8;

        // directed: empty stores, wrap at the extremes, ignored codes, clamped dimensions
        plan.push_back(product_row(1'b1, 32'd0));
        plan.push_back(reg_row(imm_pkg::REG_ROWS_A, 4'd1));
        plan.push_back(reg_row(imm_pkg::REG_INNER_DIM, 4'd1));
        plan.push_back(reg_row(imm_pkg::REG_COLS_B, 4'd1));
        plan.push_back(reg_row(REG_UNUSED, 4'd15));
        plan.push_back(load_row(imm_pkg::MODE_LOAD_A, 0, 0, 32'h7FFF_FFFF));
        plan.push_back(load_row(imm_pkg::MODE_LOAD_B, 0, 0, 32'h7FFF_FFFF));
        plan.push_back(product_row(1'b1, 32'd1));
        plan.push_back(load_row(imm_pkg::MODE_LOAD_A, 0, 0, 32'h8000_0000));
        plan.push_back(load_row(imm_pkg::MODE_LOAD_B, 0, 0, 32'hFFFF_FFFF));
        plan.push_back(product_row(1'b1, 32'h8000_0000));
        plan.push_back(load_row(imm_pkg::MODE_LOAD_B, 0, 0, 32'h8000_0000));
        plan.push_back(load_row(MODE_UNUSED, 0, 0, 32'd3));
        plan.push_back(product_row(1'b1, 32'd0));
        plan.push_back(load_row(imm_pkg::MODE_LOAD_A, 7, 7, 32'h5555_AAAA));
        plan.push_back(load_row(imm_pkg::MODE_LOAD_B, 7, 7, 32'hAAAA_5555));
        plan.push_back(load_row(imm_pkg::MODE_LOAD_A, 0, 7, 32'hFFFF_FFFD));
        plan.push_back(load_row(imm_pkg::MODE_LOAD_B, 7, 0, 32'd7));
        plan.push_back(load_row(MODE_UNUSED, 7, 7, 32'hFFFF_FFFF));
        plan.push_back(reg_row(imm_pkg::REG_ROWS_A, 4'd0));
        plan.push_back(reg_row(imm_pkg::REG_INNER_DIM, 4'd15));
        plan.push_back(reg_row(imm_pkg::REG_COLS_B, 4'd9));
        plan.push_back(product_row(1'b0, 32'd0));
        plan.push_back(reg_row(imm_pkg::REG_ROWS_A, 4'd8));
        plan.push_back(reg_row(imm_pkg::REG_INNER_DIM, 4'd8));
        plan.push_back(reg_row(imm_pkg::REG_COLS_B, 4'd8));
        plan.push_back(product_row(1'b0, 32'd0));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[n])
        begin
            if (plan[n].is_reg)
            begin
                wait_idle();
                write_reg(plan[n].reg_idx, plan[n].reg_val);
            end
            else
                send_request(plan[n].req, plan[n].typed, plan[n].typed_value);
        end

        // random jobs
        while (random_items < ITEMS)
            run_job();

        calm = 1'b0;
        wait_idle();

        $display("run covered %0d requests, %0d products, %0d elements, %0d register writes",
                 request_count, product_count, element_count, reg_write_count);
        $display("mismatches seen: %0d", mismatch_count);
        if (mismatch_count == 0)
            $display("tb_integer_matrix_multiply: PASS");
        else
            $display("tb_integer_matrix_multiply: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/imm_pkg.sv
design/imm_store.sv
design/imm_seq.sv
design/imm_mac.sv
design/integer_matrix_multiply.sv
bench/tb_integer_matrix_multiply.sv
